// ===== hdl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types, request codes, status codes and cell commands for the
// bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int COUNT_W      = 5;
  localparam int VALUE_W      = 32;

  // request kinds
  localparam logic [2:0] K_PUSH_FRONT = 3'd0;
  localparam logic [2:0] K_PUSH_TAIL  = 3'd1;
  localparam logic [2:0] K_POP_FRONT  = 3'd2;
  localparam logic [2:0] K_POP_BACK   = 3'd3;
  localparam logic [2:0] K_REMOVE     = 3'd4;
  localparam logic [2:0] K_FIND       = 3'd5;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // cell commands
  localparam logic [2:0] OP_NOP        = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_TAIL  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_SCAN_REM   = 3'd4;
  localparam logic [2:0] OP_SCAN_FIND  = 3'd5;

  typedef struct packed {
    logic [2:0]                kind;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic [2:0]         op;
    logic               run;
    logic [VALUE_W-1:0] key;
  } cell_cmd_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic tok;
    logic hit;
  } tok_t;

endpackage

// ===== hdl/bounded_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_list_engine
// Ordered list of up to CAPACITY signed 32-bit values with push, pop,
// remove and find requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request (kind, value); every request
//   gives exactly one result on out_valid/out_ready/out_data (status, found,
//   count). Push front, push back, pop front, pop back and unused kinds
//   finish at once: the result goes to the output register when it is free,
//   else to the pending slot. Remove and find on a list of L entries send a
//   token down the row of cells, one cell per cycle; on an empty list they
//   finish at once as well. A new request is taken once the previous one has
//   finished its work, even while its result still waits in the output
//   register; if the receiver stalls and a second result is ready, it is
//   held and no further request is taken until the first one drains.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; entry storage is not cleared.
// ----------------------------------------------------------------------------
module bounded_list_engine #(
  parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ble_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ble_pkg::out_item_t out_data
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [LW-1:0]               len_r, len_nxt;
  logic [CW-1:0]               scan_r, scan_nxt;
  logic                        hit_r, hit_nxt;
  logic                        rem_r, rem_nxt;
  logic [ble_pkg::VALUE_W-1:0] key_r, key_nxt;
  logic                        out_vld_r, out_vld_nxt;
  ble_pkg::out_item_t          out_r, out_nxt;
  ble_pkg::out_item_t          pend_r, pend_nxt;

  ble_pkg::cell_cmd_t          cmd;
  logic                        start;
  logic                        res_vld;
  ble_pkg::out_item_t          res;
  logic                        slot_free;
  logic                        any_match;
  logic                        hit_any;
  logic                        full;
  logic                        empty;
  logic                        last;

  logic [ble_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  ble_pkg::tok_t               cell_tok  [CAPACITY];
  logic [CAPACITY-1:0]         match_vec;
  logic [CAPACITY-1:0]         tok_vec;

  // --------------------------------------------------------------------------
  // row of cells
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ble_pkg::VALUE_W-1:0] left_d, right_d;
    ble_pkg::tok_t               tin;

    if (i == 0) begin : g_head
      assign left_d  = cmd.key;
      assign tin.tok = start;
      assign tin.hit = 1'b0;
    end else begin : g_body
      assign left_d = cell_data[i-1];
      assign tin    = cell_tok[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end

    ble_cell #(
      .IDX (i),
      .LW  (LW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .len        (len_r),
      .left_data  (left_d),
      .right_data (right_d),
      .tok_in     (tin),
      .tok_out    (cell_tok[i]),
      .match      (match_vec[i]),
      .data       (cell_data[i])
    );

    assign tok_vec[i] = cell_tok[i].tok;
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  assign any_match = |match_vec;
  assign hit_any   = hit_r || any_match;
  assign full      = (len_r == LW'(CAPACITY));
  assign empty     = (len_r == '0);
  assign last      = ((LW'(scan_r) + LW'(1)) == len_r);
  assign slot_free = !out_vld_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    scan_nxt    = scan_r;
    hit_nxt     = hit_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    pend_nxt    = pend_r;
    cmd.op      = ble_pkg::OP_NOP;
    cmd.run     = 1'b0;
    cmd.key     = key_r;
    start       = 1'b0;
    res_vld     = 1'b0;
    res.status  = ble_pkg::ST_OK;
    res.found   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        cmd.key = $unsigned(in_data.value);
        if (in_valid) begin
          key_nxt = $unsigned(in_data.value);
          res_vld = 1'b1;
          unique case (in_data.kind)
            ble_pkg::K_PUSH_FRONT, ble_pkg::K_PUSH_TAIL: begin
              if (full) begin
                res.status = ble_pkg::ST_FULL;
              end else begin
                cmd.op  = (in_data.kind == ble_pkg::K_PUSH_FRONT) ?
                          ble_pkg::OP_PUSH_FRONT : ble_pkg::OP_PUSH_TAIL;
                len_nxt = len_r + LW'(1);
              end
            end
            ble_pkg::K_POP_FRONT, ble_pkg::K_POP_BACK: begin
              if (empty) begin
                res.status = ble_pkg::ST_EMPTY;
              end else begin
                if (in_data.kind == ble_pkg::K_POP_FRONT) cmd.op = ble_pkg::OP_POP_FRONT;
                len_nxt = len_r - LW'(1);
              end
            end
            ble_pkg::K_REMOVE, ble_pkg::K_FIND: begin
              if (empty) begin
                if (in_data.kind == ble_pkg::K_REMOVE) res.status = ble_pkg::ST_EMPTY;
              end else begin
                // launch the token into the first cell
                res_vld   = 1'b0;
                start     = 1'b1;
                cmd.run   = 1'b1;
                scan_nxt  = '0;
                hit_nxt   = 1'b0;
                rem_nxt   = (in_data.kind == ble_pkg::K_REMOVE);
                state_nxt = S_SCAN;
              end
            end
            default: res.status = ble_pkg::ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        // drop the token once it leaves the last cell in range
        cmd.run  = !last;
        cmd.op   = rem_r ? ble_pkg::OP_SCAN_REM : ble_pkg::OP_SCAN_FIND;
        hit_nxt  = hit_any;
        scan_nxt = scan_r + CW'(1);
        if (last) begin
          res_vld   = 1'b1;
          state_nxt = S_IDLE;
          if (rem_r) begin
            if (hit_any) begin
              len_nxt = len_r - LW'(1);
            end else begin
              res.status = ble_pkg::ST_NOTFOUND;
            end
          end else begin
            res.found = hit_any;
          end
        end
      end
      S_WAIT: begin
        cmd.op = ble_pkg::OP_NOP;
      end
      default: state_nxt = S_IDLE;
    endcase

    res.count = (ble_pkg::COUNT_W)'(len_nxt);

    // output register and one pending slot
    if (state_r == S_WAIT) begin
      if (slot_free) begin
        out_nxt     = pend_r;
        out_vld_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end
    end else if (res_vld) begin
      if (slot_free) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        pend_nxt  = res;
        state_nxt = S_WAIT;
      end
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      len_r     <= '0;
      scan_r    <= '0;
      hit_r     <= 1'b0;
      rem_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      scan_r    <= scan_nxt;
      hit_r     <= hit_nxt;
      rem_r     <= rem_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("list length above capacity");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (len_r != '0))
    else $error("scan running on empty list");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> $onehot(tok_vec))
    else $error("scan token lost or duplicated");

  a_wait_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> out_vld_r)
    else $error("pending result without a blocked output");

endmodule

// ===== hdl/ble_cell.sv =====
// ----------------------------------------------------------------------------
// ble_cell
// One list position: holds an entry, shifts with its neighbors and passes
// the search token along the chain.
// ----------------------------------------------------------------------------
module ble_cell #(
  parameter int IDX = 0,
  parameter int LW  = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ble_pkg::cell_cmd_t              cmd,
  input  logic [LW-1:0]                   len,
  input  logic [ble_pkg::VALUE_W-1:0]     left_data,
  input  logic [ble_pkg::VALUE_W-1:0]     right_data,
  input  ble_pkg::tok_t                   tok_in,
  output ble_pkg::tok_t                   tok_out,
  output logic                            match,
  output logic [ble_pkg::VALUE_W-1:0]     data
);

  logic [ble_pkg::VALUE_W-1:0] data_r, data_nxt;
  ble_pkg::tok_t               tok_r, tok_nxt;
  logic                        in_range;
  logic                        scanning;
  logic                        hit_now;

  assign in_range = LW'(IDX) < len;
  assign scanning = (cmd.op == ble_pkg::OP_SCAN_REM) || (cmd.op == ble_pkg::OP_SCAN_FIND);
  assign match    = tok_r.tok && scanning && in_range && (data_r == cmd.key);
  assign hit_now  = tok_r.hit || match;

  assign tok_out.tok = tok_r.tok;
  assign tok_out.hit = tok_r.tok && hit_now;
  assign data        = data_r;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      ble_pkg::OP_PUSH_FRONT: data_nxt = left_data;
      ble_pkg::OP_PUSH_TAIL: begin
        if (LW'(IDX) == len) data_nxt = cmd.key;
      end
      ble_pkg::OP_POP_FRONT: data_nxt = right_data;
      // close the gap from the first match onward
      ble_pkg::OP_SCAN_REM: begin
        if (tok_r.tok && hit_now) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  assign tok_nxt = cmd.run ? tok_in : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== tb/bounded_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_list_engine_tb
// Self-checking bench for the bounded list engine. Requests come first from a
// short table of edge cases, then from a long random stream that swings the
// list between empty and full. A behavioral copy of the list predicts every
// result, and each result from the block is compared field by field.
// ----------------------------------------------------------------------------
module bounded_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = ble_pkg::CAPACITY_DEF;
  localparam int VALUE_W      = ble_pkg::VALUE_W;
  localparam int COUNT_W      = ble_pkg::COUNT_W;
  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 4;

  localparam logic [2:0] K_SPARE_6 = 3'd6;
  localparam logic [2:0] K_SPARE_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {GROW, SHRINK, MIXED} bias_t;

  typedef struct {
    ble_pkg::in_item_t  req;
    bit                 typed;
    ble_pkg::out_item_t want;
  } table_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ble_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ble_pkg::out_item_t out_data;

  // behavioral copy of the list
  logic signed [VALUE_W-1:0] list_vals [CAPACITY];
  int                        list_len;

  ble_pkg::out_item_t pending_results [$];
  table_row_t         directed_rows [$];
  int                 error_count = 0;
  int                 hold_reqs = 0;
  bit                 run_done;

  bounded_list_engine #(.CAPACITY(CAPACITY)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic ble_pkg::out_item_t apply_request(input ble_pkg::in_item_t req);
    ble_pkg::out_item_t res;
    int                 i;
    int                 hit;
    res.status = ble_pkg::ST_OK;
    res.found  = 1'b0;
    hit        = -1;
    case (req.kind)
      ble_pkg::K_PUSH_FRONT: begin
        if (list_len >= CAPACITY) begin
          res.status = ble_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = req.value;
          list_len++;
        end
      end
      ble_pkg::K_PUSH_TAIL: begin
        if (list_len >= CAPACITY) begin
          res.status = ble_pkg::ST_FULL;
        end else begin
          list_vals[list_len] = req.value;
          list_len++;
        end
      end
      ble_pkg::K_POP_FRONT: begin
        if (list_len == 0) begin
          res.status = ble_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      ble_pkg::K_POP_BACK: begin
        if (list_len == 0) res.status = ble_pkg::ST_EMPTY;
        else list_len--;
      end
      ble_pkg::K_REMOVE: begin
        if (list_len == 0) begin
          res.status = ble_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i < list_len && hit < 0; i++)
            if (list_vals[i] == req.value) hit = i;
          if (hit < 0) begin
            res.status = ble_pkg::ST_NOTFOUND;
          end else begin
            for (i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
            list_len--;
          end
        end
      end
      ble_pkg::K_FIND: begin
        for (i = 0; i < list_len; i++)
          if (list_vals[i] == req.value) res.found = 1'b1;
      end
      default: begin
      end
    endcase
    res.count = list_len[COUNT_W-1:0];
    return res;
  endfunction

  function automatic table_row_t mk_row(input logic [2:0] kind,
                                        input logic signed [VALUE_W-1:0] value,
                                        input bit typed,
                                        input logic [1:0] status,
                                        input logic found,
                                        input int count);
    table_row_t row;
    row.req.kind     = kind;
    row.req.value    = value;
    row.typed        = typed;
    row.want.status  = status;
    row.want.found   = found;
    row.want.count   = count[COUNT_W-1:0];
    return row;
  endfunction

  task automatic add_row(input table_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Called right after a falling edge; returns right after the falling edge
  // that follows acceptance.
  task automatic offer_request(input ble_pkg::in_item_t req, input int gap,
                               input bit typed, input ble_pkg::out_item_t want);
    ble_pkg::out_item_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_request(req);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // result side
  initial begin
    int                 stall;
    int                 taken;
    int                 holds_done;
    bit                 burst;
    ble_pkg::out_item_t exp_res;
    out_ready  = 1'b0;
    taken      = 0;
    holds_done = 0;
    burst      = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (taken % 150 == 0) burst = ($urandom_range(0, 3) == 0);
      if (holds_done != hold_reqs) begin
        stall = HOLD_CYCLES;
        holds_done++;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d found=%0d count=%0d",
                                  out_data.status, out_data.found, out_data.count));
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.status !== exp_res.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, exp_res.status));
        if (out_data.found !== exp_res.found)
          report_mismatch($sformatf("found got %0d want %0d",
                                    out_data.found, exp_res.found));
        if (out_data.count !== exp_res.count)
          report_mismatch($sformatf("count got %0d want %0d",
                                    out_data.count, exp_res.count));
      end
      @(negedge clk);
    end
  end

  // watchdog: cycles with no request or result moving
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT && !run_done) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    if (!run_done) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // request side
  initial begin
    logic signed [VALUE_W-1:0] pool [8];
    ble_pkg::in_item_t         req;
    ble_pkg::out_item_t        none;
    bias_t                     bias;
    int                        bias_left;
    int                        gap;
    int                        n;
    int                        r;
    bit                        burst;

    pool = '{32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd42, -32'sd100, VAL_MIN, VAL_MAX};
    none        = '0;
    run_done    = 1'b0;
    list_len    = 0;
    in_valid    = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;

    // empty list cases
    add_row(mk_row(ble_pkg::K_POP_FRONT, 32'sd0, 1, ble_pkg::ST_EMPTY, 1'b0, 0));
    add_row(mk_row(ble_pkg::K_POP_BACK, -32'sd1, 1, ble_pkg::ST_EMPTY, 1'b0, 0));
    add_row(mk_row(ble_pkg::K_REMOVE, 32'sd5, 1, ble_pkg::ST_EMPTY, 1'b0, 0));
    add_row(mk_row(ble_pkg::K_FIND, 32'sd0, 1, ble_pkg::ST_OK, 1'b0, 0));
    add_row(mk_row(K_SPARE_6, 32'sd0, 1, ble_pkg::ST_OK, 1'b0, 0));
    add_row(mk_row(K_SPARE_7, -32'sd1, 1, ble_pkg::ST_OK, 1'b0, 0));
    // extremes of the value range
    add_row(mk_row(ble_pkg::K_PUSH_TAIL, VAL_MIN, 1, ble_pkg::ST_OK, 1'b0, 1));
    add_row(mk_row(ble_pkg::K_PUSH_FRONT, VAL_MAX, 1, ble_pkg::ST_OK, 1'b0, 2));
    add_row(mk_row(ble_pkg::K_FIND, VAL_MIN, 1, ble_pkg::ST_OK, 1'b1, 2));
    add_row(mk_row(ble_pkg::K_REMOVE, 32'sd0, 1, ble_pkg::ST_NOTFOUND, 1'b0, 2));
    // fill up, with duplicates
    for (n = 0; n < CAPACITY - 2; n++)
      add_row(mk_row(n[0] ? ble_pkg::K_PUSH_FRONT : ble_pkg::K_PUSH_TAIL,
                     (n % 4 == 0) ? 32'sd7 : $signed(32'h5555_5555 << n),
                     0, ble_pkg::ST_OK, 1'b0, 0));
    add_row(mk_row(ble_pkg::K_PUSH_TAIL, 32'sd3, 1, ble_pkg::ST_FULL, 1'b0, CAPACITY));
    add_row(mk_row(ble_pkg::K_PUSH_FRONT, -32'sd3, 1, ble_pkg::ST_FULL, 1'b0, CAPACITY));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].req, $urandom_range(0, 3),
                    directed_rows[i].typed, directed_rows[i].want);

    bias      = MIXED;
    bias_left = 0;
    burst     = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == 400 || n == 1300) hold_reqs++;
      if (n == 900) begin
        // let everything drain before going on
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      if (bias_left == 0) begin
        bias      = bias_t'($urandom_range(0, 2));
        bias_left = $urandom_range(20, 80);
      end
      bias_left--;

      r = $urandom_range(0, 99);
      if (r < 3) begin
        req.kind = $urandom_range(0, 1) ? K_SPARE_7 : K_SPARE_6;
      end else if (bias == GROW) begin
        req.kind = (r < 70) ? ($urandom_range(0, 1) ? ble_pkg::K_PUSH_FRONT
                                                     : ble_pkg::K_PUSH_TAIL)
                            : 3'($urandom_range(2, 5));
      end else if (bias == SHRINK) begin
        req.kind = (r < 70) ? 3'($urandom_range(2, 4))
                            : ($urandom_range(0, 1) ? ble_pkg::K_FIND
                                                    : 3'($urandom_range(0, 1)));
      end else begin
        req.kind = 3'($urandom_range(0, 5));
      end

      r = $urandom_range(0, 99);
      if (r < 20 && list_len > 0) req.value = list_vals[$urandom_range(0, list_len - 1)];
      else if (r < 65) req.value = pool[$urandom_range(0, 7)];
      else req.value = $urandom;

      gap = burst ? 0 : $urandom_range(0, 7);
      offer_request(req, gap, 1'b0, none);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    run_done = 1'b1;

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ble_pkg.sv
hdl/ble_cell.sv
hdl/bounded_list_engine.sv
tb/bounded_list_engine_tb.sv
